/* rtl/ipcls_pkg.sv */
// ----------------------------------------------------------------------------
// ipcls_pkg
// Shared types, codes and range checks of the IP literal classifier.
// ----------------------------------------------------------------------------
package ipcls_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_COLON,
    PH_GAP,
    PH_ELEM
  } phase_e;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_V4   = 2'd1;
  localparam logic [1:0] KIND_V6   = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef logic [7:0] byte_t;

  function automatic logic v4_private(input byte_t b0, input byte_t b1, input byte_t b2);
    logic p;
    p = 1'b0;
    if (b0 == 8'd0 || b0 == 8'd10 || b0 == 8'd127) p = 1'b1;
    if (b0 == 8'd100 && (b1 & 8'hc0) == 8'd64) p = 1'b1;
    if (b0 == 8'd169 && b1 == 8'd254) p = 1'b1;
    if (b0 == 8'd172 && (b1 & 8'hf0) == 8'd16) p = 1'b1;
    if (b0 == 8'd192 && b1 == 8'd0 && b2 == 8'd0) p = 1'b1;
    if (b0 == 8'd192 && b1 == 8'd168) p = 1'b1;
    if (b0 == 8'd198 && (b1 & 8'hfe) == 8'd18) p = 1'b1;
    if ((b0 & 8'hf0) == 8'd224) p = 1'b1;
    if (b0 >= 8'd240) p = 1'b1;
    return p;
  endfunction

  function automatic logic v6_private(input logic [127:0] a);
    logic p;
    p = 1'b0;
    if (a[127:8] == '0 && a[7:0] <= 8'd1) begin
      p = 1'b1;
    end else if (a[127:48] == '0 && (a[47:32] == 16'hffff || a[47:32] == 16'h0000)) begin
      p = v4_private(a[31:24], a[23:16], a[15:8]);
    end else if (a[127:96] == 32'h0064ff9b && a[95:32] == '0) begin
      p = v4_private(a[31:24], a[23:16], a[15:8]);
    end else if ((a[127:120] & 8'hfe) == 8'hfc) begin
      p = 1'b1;
    end else if (a[127:120] == 8'hfe && (a[119:112] & 8'hc0) == 8'h80) begin
      p = 1'b1;
    end else if (a[127:120] == 8'hff) begin
      p = 1'b1;
    end
    return p;
  endfunction

endpackage

/* rtl/ipcls_if.sv */
// ----------------------------------------------------------------------------
// ipcls_in_if / ipcls_out_if
// Valid/ready channels for characters in and classification results out.
// ----------------------------------------------------------------------------
interface ipcls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_req;
  modport source (output valid, output character, output end_req, input ready);
  modport sink   (input valid, input character, input end_req, output ready);
endinterface

interface ipcls_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        is_private;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  modport source (output valid, output kind, output is_private, output addr_high,
                  output addr_low, input ready);
  modport sink   (input valid, input kind, input is_private, input addr_high,
                  input addr_low, output ready);
endinterface

/* rtl/ip_literal_private_classifier_unit.sv */
// ----------------------------------------------------------------------------
// ip_literal_private_classifier_unit
// Parses a textual IPv4 or IPv6 literal and flags private address ranges.
// ----------------------------------------------------------------------------
// Usage: the address text arrives on in_i one byte per request; a request
// with end_req set closes the string. Character requests give no result. The
// end request gives one result on out_o: kind, is_private and the address.
// A dotted-quad parser and an IPv6 parser run side by side on every byte.
// Throughput is one request per cycle unless a result stalls. A result
// appears in the cycle after its end request is accepted; the gap expansion
// and the range checks are logic between the parser and result registers.
// The result register is the only buffer on the output side: while a result
// waits and out_o.ready is low, in_i.ready drops, otherwise requests are
// taken every cycle even while the result is being taken.
// After the end request all parser state returns to its reset values.
// Reset (rst_ni low) clears the parsers and drops out_o.valid.
// ----------------------------------------------------------------------------
module ip_literal_private_classifier_unit
  import ipcls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ipcls_in_if.sink    in_i,
  ipcls_out_if.source out_o
);

  logic       v4_alive_q, v4_alive_d, v4_lead_q, v4_lead_d;
  logic [1:0] v4_idx_q, v4_idx_d, v4_dig_q, v4_dig_d;
  logic [7:0] v4_val_q, v4_val_d;
  byte_t      v4_oct_q [3], v4_oct_d [3];

  logic       v6_alive_q, v6_alive_d, gap_seen_q, gap_seen_d;
  phase_e     phase_q, phase_d;
  byte_t      bytes_q [16], bytes_d [16];
  logic [4:0] cnt_q, cnt_d, gap_q, gap_d;
  logic [15:0] gv_q, gv_d;
  logic [2:0] gd_q, gd_d;
  logic [7:0] dec_q, dec_d;
  logic       all_q, all_d, tldot_q, tldot_d, tlead_q, tlead_d;
  logic [1:0] tlf_q, tlf_d, tld_q, tld_d;
  byte_t      tloct_q [3], tloct_d [3];
  logic       any_q, any_d;

  logic        out_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic        priv_q, priv_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;

  logic       fire, is_dec, is_hex, is_colon, is_dot, cg_ok;
  logic [3:0] dval, hval;
  logic [7:0] ch;
  logic [11:0] v4_prod, tl_prod;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign ch         = in_i.character;
  assign is_dec     = ch >= 8'h30 && ch <= 8'h39;
  assign is_colon   = ch == CH_COLON;
  assign is_dot     = ch == CH_DOT;
  assign dval       = ch[3:0];

  always_comb begin
    is_hex = 1'b1;
    hval   = ch[3:0];
    if (is_dec) begin
      hval = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      hval = ch[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign v4_prod = ({4'b0, v4_val_q} << 3) + ({4'b0, v4_val_q} << 1) + {8'b0, dval};
  assign cg_ok   = !tldot_q && gd_q != 3'd0 && gd_q <= 3'd4 && cnt_q <= 5'd14;

  // Character path: both parsers step on one byte; an end request resets them.
  always_comb begin
    logic       e_all, e_tldot, e_tlead;
    logic [1:0] e_tlf, e_tld;
    logic [7:0] e_dec;
    logic [15:0] e_gv;
    logic [2:0] e_gd;
    logic       do_elem, begin_el;
    v4_alive_d = v4_alive_q; v4_lead_d = v4_lead_q; v4_idx_d = v4_idx_q;
    v4_dig_d = v4_dig_q; v4_val_d = v4_val_q; v4_oct_d = v4_oct_q;
    v6_alive_d = v6_alive_q; gap_seen_d = gap_seen_q; phase_d = phase_q;
    bytes_d = bytes_q; cnt_d = cnt_q; gap_d = gap_q; gv_d = gv_q; gd_d = gd_q;
    dec_d = dec_q; all_d = all_q; tldot_d = tldot_q; tlead_d = tlead_q;
    tlf_d = tlf_q; tld_d = tld_q; tloct_d = tloct_q; any_d = any_q;
    do_elem = 1'b0; begin_el = 1'b0;
    e_all = all_q; e_tldot = tldot_q; e_tlead = tlead_q; e_tlf = tlf_q;
    e_tld = tld_q; e_dec = dec_q; e_gv = gv_q; e_gd = gd_q;
    tl_prod = '0;

    if (fire && in_i.end_req) begin
      v4_alive_d = 1'b1; v4_lead_d = 1'b0; v4_idx_d = '0; v4_dig_d = '0; v4_val_d = '0;
      v6_alive_d = 1'b1; gap_seen_d = 1'b0; phase_d = PH_START;
      cnt_d = '0; gap_d = '0; gv_d = '0; gd_d = '0; dec_d = '0; all_d = 1'b1;
      tldot_d = 1'b0; tlead_d = 1'b0; tlf_d = '0; tld_d = '0; any_d = 1'b0;
      for (int i = 0; i < 3; i++) begin
        v4_oct_d[i] = '0;
        tloct_d[i]  = '0;
      end
      for (int i = 0; i < 16; i++) bytes_d[i] = '0;
    end else if (fire) begin
      any_d = 1'b1;
      if (v4_alive_q) begin
        if (is_dec) begin
          if (v4_dig_q == 2'd0) v4_lead_d = (dval == 4'd0);
          if (v4_dig_q != 2'd0 && v4_lead_q) begin
            v4_alive_d = 1'b0;
          end else if (v4_prod > 12'd255 || v4_dig_q == 2'd3) begin
            v4_alive_d = 1'b0;
          end else begin
            v4_val_d = v4_prod[7:0];
            v4_dig_d = v4_dig_q + 2'd1;
          end
        end else if (is_dot) begin
          if (v4_dig_q == 2'd0 || v4_idx_q == 2'd3) begin
            v4_alive_d = 1'b0;
          end else begin
            v4_oct_d[v4_idx_q] = v4_val_q;
            v4_idx_d = v4_idx_q + 2'd1;
            v4_val_d = '0; v4_dig_d = '0; v4_lead_d = 1'b0;
          end
        end else begin
          v4_alive_d = 1'b0;
        end
      end

      if (v6_alive_q) begin
        case (phase_q)
          PH_START: begin
            if (is_colon) phase_d = PH_LEAD;
            else begin do_elem = 1'b1; begin_el = 1'b1; end
          end
          PH_LEAD: begin
            if (is_colon) begin
              gap_seen_d = 1'b1; gap_d = '0; phase_d = PH_GAP;
            end else v6_alive_d = 1'b0;
          end
          PH_COLON: begin
            if (is_colon) begin
              if (gap_seen_q) v6_alive_d = 1'b0;
              else begin gap_seen_d = 1'b1; gap_d = cnt_q; phase_d = PH_GAP; end
            end else begin do_elem = 1'b1; begin_el = 1'b1; end
          end
          PH_GAP: begin
            if (is_colon) v6_alive_d = 1'b0;
            else begin do_elem = 1'b1; begin_el = 1'b1; end
          end
          default: begin
            if (is_colon) begin
              if (!cg_ok) v6_alive_d = 1'b0;
              else begin
                bytes_d[cnt_q[3:0]]        = gv_q[15:8];
                bytes_d[cnt_q[3:0] + 4'd1] = gv_q[7:0];
                cnt_d   = cnt_q + 5'd2;
                phase_d = PH_COLON;
              end
            end else do_elem = 1'b1;
          end
        endcase

        if (do_elem) begin
          if (begin_el) begin
            e_gv = '0; e_gd = '0; e_dec = '0; e_all = 1'b1;
            e_tldot = 1'b0; e_tlf = '0; e_tld = '0; e_tlead = 1'b0;
          end
          phase_d = PH_ELEM;
          tl_prod = ({4'b0, e_dec} << 3) + ({4'b0, e_dec} << 1) + {8'b0, dval};
          if (is_dot) begin
            if (e_tld == 2'd0 || e_tlf == 2'd3) begin
              e_all = 1'b0;
            end else if (e_all) begin
              tloct_d[e_tlf] = e_dec;
              e_tlf = e_tlf + 2'd1;
              e_dec = '0; e_tld = '0; e_tlead = 1'b0;
            end
            e_tldot = 1'b1;
          end else if (!is_hex) begin
            v6_alive_d = 1'b0;
          end else begin
            if (e_gd < 3'd5) e_gd = e_gd + 3'd1;
            e_gv = {e_gv[11:0], hval};
            if (e_all) begin
              if (!is_dec) begin
                e_all = 1'b0;
              end else begin
                if (e_tld == 2'd0) e_tlead = (dval == 4'd0);
                if (e_tld != 2'd0 && e_tlead) e_all = 1'b0;
                else if (tl_prod > 12'd255 || e_tld == 2'd3) e_all = 1'b0;
                else begin
                  e_dec = tl_prod[7:0];
                  e_tld = e_tld + 2'd1;
                end
              end
            end
          end
          gv_d = e_gv; gd_d = e_gd; dec_d = e_dec; all_d = e_all;
          tldot_d = e_tldot; tlf_d = e_tlf; tld_d = e_tld; tlead_d = e_tlead;
        end
      end
    end
  end

  // End path: close the last element, expand the gap and classify.
  always_comb begin
    byte_t      fb [16];
    byte_t      ex [16];
    logic [4:0] cnt_e, lim;
    logic       v6_ok, v4_ok, ct_ok;
    logic [127:0] a;
    for (int i = 0; i < 16; i++) fb[i] = bytes_q[i];
    cnt_e = cnt_q;
    v6_ok = 1'b0;
    ct_ok = all_q && tlf_q == 2'd3 && tld_q != 2'd0 && cnt_q <= 5'd12;
    if (phase_q == PH_GAP) begin
      v6_ok = 1'b1;
    end else if (phase_q == PH_ELEM) begin
      if (tldot_q) begin
        v6_ok = ct_ok;
        fb[cnt_q[3:0]]        = tloct_q[0];
        fb[cnt_q[3:0] + 4'd1] = tloct_q[1];
        fb[cnt_q[3:0] + 4'd2] = tloct_q[2];
        fb[cnt_q[3:0] + 4'd3] = dec_q;
        cnt_e = cnt_q + 5'd4;
      end else begin
        v6_ok = cg_ok;
        fb[cnt_q[3:0]]        = gv_q[15:8];
        fb[cnt_q[3:0] + 4'd1] = gv_q[7:0];
        cnt_e = cnt_q + 5'd2;
      end
    end
    if (!gap_seen_q) v6_ok = v6_ok && cnt_e == 5'd16;
    else v6_ok = v6_ok && cnt_e < 5'd16 && gap_q <= cnt_e;
    v6_ok = v6_ok && v6_alive_q && any_q;
    lim = 5'd16 - cnt_e + gap_q;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < gap_q) ex[i] = fb[i];
      else if (5'(i) >= lim) ex[i] = fb[4'(i) + cnt_e[3:0]];
      else ex[i] = '0;
      a[127 - 8*i -: 8] = ex[i];
    end
    v4_ok = any_q && v4_alive_q && v4_idx_q == 2'd3 && v4_dig_q != 2'd0;
    kind_d = KIND_NONE; priv_d = 1'b1; hi_d = '0; lo_d = '0;
    if (v4_ok) begin
      kind_d = KIND_V4;
      priv_d = v4_private(v4_oct_q[0], v4_oct_q[1], v4_oct_q[2]);
      lo_d   = {32'b0, v4_oct_q[0], v4_oct_q[1], v4_oct_q[2], v4_val_q};
    end else if (v6_ok) begin
      kind_d = KIND_V6;
      priv_d = v6_private(a);
      hi_d   = a[127:64];
      lo_d   = a[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_alive_q <= 1'b1; v4_lead_q <= 1'b0; v4_idx_q <= '0; v4_dig_q <= '0;
      v4_val_q <= '0;
      v6_alive_q <= 1'b1; gap_seen_q <= 1'b0; phase_q <= PH_START;
      cnt_q <= '0; gap_q <= '0; gv_q <= '0; gd_q <= '0; dec_q <= '0; all_q <= 1'b1;
      tldot_q <= 1'b0; tlead_q <= 1'b0; tlf_q <= '0; tld_q <= '0; any_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        v4_oct_q[i] <= '0;
        tloct_q[i]  <= '0;
      end
      for (int i = 0; i < 16; i++) bytes_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v4_alive_q <= v4_alive_d; v4_lead_q <= v4_lead_d; v4_idx_q <= v4_idx_d;
      v4_dig_q <= v4_dig_d; v4_val_q <= v4_val_d; v4_oct_q <= v4_oct_d;
      v6_alive_q <= v6_alive_d; gap_seen_q <= gap_seen_d; phase_q <= phase_d;
      bytes_q <= bytes_d; cnt_q <= cnt_d; gap_q <= gap_d; gv_q <= gv_d; gd_q <= gd_d;
      dec_q <= dec_d; all_q <= all_d; tldot_q <= tldot_d; tlead_q <= tlead_d;
      tlf_q <= tlf_d; tld_q <= tld_d; tloct_q <= tloct_d; any_q <= any_d;
      if (fire && in_i.end_req) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_i.end_req) begin
      kind_q <= kind_d; priv_q <= priv_d; hi_q <= hi_d; lo_q <= lo_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.is_private = priv_q;
  assign out_o.addr_high  = hi_q;
  assign out_o.addr_low   = lo_q;

endmodule

/* rtl/ipcls_checker.sv */
// ----------------------------------------------------------------------------
// ipcls_checker
// Port-level assertions for the IP literal classifier, bound to the top.
// ----------------------------------------------------------------------------
module ipcls_checker
  import ipcls_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_end_req_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic        out_is_private_i,
  input logic [63:0] out_addr_high_i,
  input logic [63:0] out_addr_low_i
);

  // A stalled result must stay valid and keep its kind and low address bits.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_low_i)
      && $stable(out_kind_i))
    else $error("stalled result changed");

  // Every accepted end request yields a result in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_req_i |=> out_valid_i)
    else $error("end request gave no result");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_NONE |-> out_is_private_i
      && out_addr_high_i == '0 && out_addr_low_i == '0)
    else $error("unparseable result not private or not zero");

  a_v4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_V4 |-> out_addr_high_i == '0
      && out_addr_low_i[63:32] == '0)
    else $error("IPv4 result with upper address bits set");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_kind_i != 2'd3)
    else $error("invalid kind code");

endmodule

bind ip_literal_private_classifier_unit ipcls_checker u_ipcls_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_end_req_i     (in_i.end_req),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_is_private_i (out_o.is_private),
  .out_addr_high_i  (out_o.addr_high),
  .out_addr_low_i   (out_o.addr_low)
);

/* tb/ipcls_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipcls_tb_checker
// Watches both channels of the classifier and predicts every result from the
// accepted character requests, comparing each result field by field.
// ----------------------------------------------------------------------------
module ipcls_tb_checker
  import ipcls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ipcls_in_if  in_m,
  ipcls_out_if out_m,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o
);

  typedef byte_t addr_bytes_t [16];

  typedef struct {
    logic [1:0]  kind;
    logic        is_private;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } verdict_t;

  verdict_t verdict_q[$];

  // Dotted-quad parser.
  logic  quad_ok, quad_lz;
  int    quad_idx, quad_val, quad_dig;
  byte_t quad_oct [4];
  // IPv6 parser and its dotted tail.
  logic        hex_ok, gap_seen, all_dec, tail_dot, tail_lead, any_seen;
  phase_e      phase;
  addr_bytes_t hex_bytes;
  int          byte_cnt, gap_off, grp_dig, elem_dec, tail_field, tail_dig;
  logic [15:0] grp_val;
  byte_t       tail_oct [4];

  assign pending_o = verdict_q.size();

  function automatic int hex_nibble(byte_t c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function void clear_parsers();
    quad_ok = 1'b1; quad_idx = 0; quad_val = 0; quad_dig = 0; quad_lz = 1'b0;
    hex_ok = 1'b1; phase = PH_START; byte_cnt = 0; gap_off = 0; gap_seen = 1'b0;
    grp_val = '0; grp_dig = 0; elem_dec = 0; all_dec = 1'b1; any_seen = 1'b0;
    tail_dot = 1'b0; tail_field = 0; tail_dig = 0; tail_lead = 1'b0;
    for (int i = 0; i < 16; i++) hex_bytes[i] = '0;
    for (int i = 0; i < 4; i++) begin
      quad_oct[i] = '0;
      tail_oct[i] = '0;
    end
  endfunction

  function void quad_feed(byte_t c);
    int v;
    if (!quad_ok) return;
    if (c >= "0" && c <= "9") begin
      if (quad_dig == 0) quad_lz = (c == "0");
      else if (quad_lz) begin
        quad_ok = 1'b0;
        return;
      end
      v = quad_val * 10 + (c - "0");
      if (v > 255 || quad_dig >= 3) begin
        quad_ok = 1'b0;
        return;
      end
      quad_val = v;
      quad_dig++;
    end else if (c == CH_DOT) begin
      if (quad_dig == 0 || quad_idx >= 3) begin
        quad_ok = 1'b0;
        return;
      end
      quad_oct[quad_idx] = quad_val[7:0];
      quad_idx++;
      quad_val = 0; quad_dig = 0; quad_lz = 1'b0;
    end else begin
      quad_ok = 1'b0;
    end
  endfunction

  function void open_element();
    grp_val = '0; grp_dig = 0; elem_dec = 0; all_dec = 1'b1;
    tail_dot = 1'b0; tail_field = 0; tail_dig = 0; tail_lead = 1'b0;
    phase = PH_ELEM;
  endfunction

  function void element_feed(byte_t c);
    int h, v;
    h = hex_nibble(c);
    if (c == CH_DOT) begin
      if (tail_dig == 0 || tail_field >= 3) all_dec = 1'b0;
      else if (all_dec) begin
        tail_oct[tail_field] = elem_dec[7:0];
        tail_field++;
        elem_dec = 0; tail_dig = 0; tail_lead = 1'b0;
      end
      tail_dot = 1'b1;
      return;
    end
    if (h < 0) begin
      hex_ok = 1'b0;
      return;
    end
    if (grp_dig < 5) grp_dig++;
    grp_val = {grp_val[11:0], h[3:0]};
    if (!all_dec) return;
    if (c > "9") begin
      all_dec = 1'b0;
      return;
    end
    if (tail_dig == 0) tail_lead = (h == 0);
    else if (tail_lead) begin
      all_dec = 1'b0;
      return;
    end
    v = elem_dec * 10 + h;
    if (v > 255 || tail_dig >= 3) begin
      all_dec = 1'b0;
      return;
    end
    elem_dec = v;
    tail_dig++;
  endfunction

  function logic close_group();
    if (tail_dot || grp_dig == 0 || grp_dig > 4 || byte_cnt > 14) return 1'b0;
    hex_bytes[byte_cnt]     = grp_val[15:8];
    hex_bytes[byte_cnt + 1] = grp_val[7:0];
    byte_cnt += 2;
    return 1'b1;
  endfunction

  function logic close_tail();
    if (!all_dec || tail_field != 3 || tail_dig == 0 || byte_cnt > 12) return 1'b0;
    tail_oct[3] = elem_dec[7:0];
    for (int i = 0; i < 4; i++) hex_bytes[byte_cnt + i] = tail_oct[i];
    byte_cnt += 4;
    return 1'b1;
  endfunction

  function void hex_feed(byte_t c);
    if (!hex_ok) return;
    case (phase)
      PH_START: begin
        if (c == CH_COLON) phase = PH_LEAD;
        else begin
          open_element();
          element_feed(c);
        end
      end
      PH_LEAD: begin
        if (c == CH_COLON) begin
          gap_seen = 1'b1; gap_off = 0; phase = PH_GAP;
        end else hex_ok = 1'b0;
      end
      PH_COLON: begin
        if (c == CH_COLON) begin
          if (gap_seen) hex_ok = 1'b0;
          else begin
            gap_seen = 1'b1; gap_off = byte_cnt; phase = PH_GAP;
          end
        end else begin
          open_element();
          element_feed(c);
        end
      end
      PH_GAP: begin
        if (c == CH_COLON) hex_ok = 1'b0;
        else begin
          open_element();
          element_feed(c);
        end
      end
      default: begin
        if (c == CH_COLON) begin
          if (!close_group()) hex_ok = 1'b0;
          else phase = PH_COLON;
        end else element_feed(c);
      end
    endcase
  endfunction

  // Moves the bytes after the double colon to the end of the address.
  function logic expand_gap();
    addr_bytes_t moved;
    int tail_len;
    if (!gap_seen) return byte_cnt == 16;
    if (byte_cnt >= 16 || gap_off > byte_cnt) return 1'b0;
    tail_len = byte_cnt - gap_off;
    for (int i = 0; i < 16; i++) moved[i] = '0;
    for (int i = 0; i < gap_off; i++) moved[i] = hex_bytes[i];
    for (int i = 0; i < tail_len; i++) moved[16 - tail_len + i] = hex_bytes[gap_off + i];
    hex_bytes = moved;
    return 1'b1;
  endfunction

  function logic hex_complete();
    logic ok;
    if (!hex_ok) return 1'b0;
    if (phase == PH_GAP) return expand_gap();
    if (phase == PH_ELEM) begin
      ok = tail_dot ? close_tail() : close_group();
      return ok && expand_gap();
    end
    return 1'b0;
  endfunction

  function automatic logic quad_reserved(byte_t a, byte_t b, byte_t c);
    case (a)
      8'd0, 8'd10, 8'd127: return 1'b1;
      8'd100: return b[7:6] == 2'b01;
      8'd169: return b == 8'd254;
      8'd172: return b[7:4] == 4'h1;
      8'd192: return b == 8'd168 || (b == 8'd0 && c == 8'd0);
      8'd198: return b[7:1] == 7'd9;
      default: return a >= 8'd224;
    endcase
  endfunction

  function automatic logic hex_reserved(addr_bytes_t b);
    logic z10, z15, nat;
    z10 = 1'b1; z15 = 1'b1;
    for (int i = 0; i < 15; i++) if (b[i] != 0) begin
      z15 = 1'b0;
      if (i < 10) z10 = 1'b0;
    end
    nat = b[0] == 8'h00 && b[1] == 8'h64 && b[2] == 8'hff && b[3] == 8'h9b;
    for (int i = 4; i < 12; i++) if (b[i] != 0) nat = 1'b0;
    if (z15 && b[15] <= 8'd1) return 1'b1;
    if (z10 && ((b[10] == 8'hff && b[11] == 8'hff) || (b[10] == 0 && b[11] == 0)))
      return quad_reserved(b[12], b[13], b[14]);
    if (nat) return quad_reserved(b[12], b[13], b[14]);
    if (b[0][7:1] == 7'h7e) return 1'b1;
    if (b[0] == 8'hfe && b[1][7:6] == 2'b10) return 1'b1;
    return b[0] == 8'hff;
  endfunction

  function verdict_t close_string();
    verdict_t v;
    v.kind = KIND_NONE; v.is_private = 1'b1; v.addr_high = '0; v.addr_low = '0;
    if (any_seen && quad_ok && quad_idx == 3 && quad_dig > 0) begin
      quad_oct[3] = quad_val[7:0];
      v.kind = KIND_V4;
      v.is_private = quad_reserved(quad_oct[0], quad_oct[1], quad_oct[2]);
      v.addr_low = {32'd0, quad_oct[0], quad_oct[1], quad_oct[2], quad_oct[3]};
    end else if (any_seen && hex_complete()) begin
      v.kind = KIND_V6;
      v.is_private = hex_reserved(hex_bytes);
      for (int i = 0; i < 8; i++) begin
        v.addr_high = {v.addr_high[55:0], hex_bytes[i]};
        v.addr_low  = {v.addr_low[55:0], hex_bytes[i + 8]};
      end
    end
    clear_parsers();
    return v;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in result %0d, %s: got %h, expected %h", results_o, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t w;
    if (!rst_ni) begin
      clear_parsers();
      fail_count_o = 0;
      results_o = 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (verdict_q.size() == 0) begin
          $display("unexpected result: kind %0d", out_m.kind);
          fail_count_o++;
        end else begin
          w = verdict_q.pop_front();
          if (out_m.kind !== w.kind) report("kind", out_m.kind, w.kind);
          if (out_m.is_private !== w.is_private)
            report("is_private", out_m.is_private, w.is_private);
          if (out_m.addr_high !== w.addr_high) report("addr_high", out_m.addr_high, w.addr_high);
          if (out_m.addr_low !== w.addr_low) report("addr_low", out_m.addr_low, w.addr_low);
        end
        results_o++;
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.end_req) verdict_q.push_back(close_string());
        else begin
          any_seen = 1'b1;
          quad_feed(in_m.character);
          hex_feed(in_m.character);
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds address strings, directed and random, to the IP literal classifier
// with random gaps and output stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import ipcls_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk_i, rst_ni;
  int   fail_count, pending, results, cycles, items_sent, strings_sent;
  byte_t text_q[$];

  ipcls_in_if  in_ch ();
  ipcls_out_if out_ch ();

  ip_literal_private_classifier_unit dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch)
  );

  ipcls_tb_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_m(in_ch), .out_m(out_ch),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.character = '0; in_ch.end_req = 1'b0;
    cycles = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** ip_literal_private_classifier_unit: FAILED **");
      $finish;
    end
  end

  // The receiver stalls at random, except for a quiet window.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready = 1'b0;
    else if (cycles > 1500 && cycles < 2500) out_ch.ready = 1'b1;
    else out_ch.ready = $urandom_range(0, 99) >= 23;
  end

  task automatic send_request(byte_t c, logic last);
    @(negedge clk_i);
    while (!(items_sent > 600 && items_sent < 900) && $urandom_range(0, 99) < 23) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1; in_ch.character = c; in_ch.end_req = last;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_request(text_q[i], 1'b0);
    send_request(byte_t'($urandom_range(0, 255)), 1'b1);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  function automatic string hex_group();
    int r, v;
    string s;
    r = $urandom_range(0, 9);
    v = r < 3 ? 0 : (r < 5 ? $urandom_range(0, 255) : $urandom_range(0, 65535));
    s = ($urandom_range(0, 3) == 0) ? $sformatf("%04h", v) : $sformatf("%0h", v);
    if ($urandom_range(0, 2) == 0) s = s.toupper();
    return s;
  endfunction

  function automatic string dotted_quad();
    int heads[12] = '{0, 10, 100, 127, 169, 172, 192, 198, 224, 239, 240, 255};
    int picks[7] = '{0, 255, 16, 168, 254, 64, 18};
    int o[4];
    o[0] = $urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : heads[$urandom_range(0, 11)];
    for (int i = 1; i < 4; i++)
      o[i] = $urandom_range(0, 1) ? $urandom_range(0, 255) : picks[$urandom_range(0, 6)];
    return $sformatf("%0d.%0d.%0d.%0d", o[0], o[1], o[2], o[3]);
  endfunction

  function automatic string hex_literal();
    string heads[6] = '{"fe80", "fc00", "fd12", "ff02", "0", "2001"};
    string parts[$];
    string s;
    int n, st, len;
    logic tail;
    case ($urandom_range(0, 5))
      0: return {"::ffff:", dotted_quad()};
      1: return {"::", dotted_quad()};
      2: return {"64:ff9b::", dotted_quad()};
      default: ;
    endcase
    tail = $urandom_range(0, 3) == 0;
    n = tail ? 7 : 8;
    for (int i = 0; i < n; i++) parts.push_back(hex_group());
    if ($urandom_range(0, 1)) parts[0] = heads[$urandom_range(0, 5)];
    if (tail) parts[6] = dotted_quad();
    s = "";
    if ($urandom_range(0, 9) < 7) begin
      st = $urandom_range(0, n - 1);
      len = $urandom_range(1, n - st);
      for (int i = 0; i < st; i++) begin
        if (i > 0) s = {s, ":"};
        s = {s, parts[i]};
      end
      s = {s, "::"};
      for (int i = st + len; i < n; i++) begin
        if (i > st + len) s = {s, ":"};
        s = {s, parts[i]};
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (i > 0) s = {s, ":"};
        s = {s, parts[i]};
      end
    end
    return s;
  endfunction

  // Random bytes, mostly from the address alphabet.
  task automatic noise_text(int len);
    string alpha;
    alpha = "0123456789abcdefABCDEF:.:.g";
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(byte_t'($urandom_range(0, 255)));
      else text_q.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
    end
  endtask

  task automatic damage_text();
    int p;
    p = (text_q.size() > 0) ? $urandom_range(0, text_q.size() - 1) : 0;
    case ($urandom_range(0, 3))
      0: if (text_q.size() > 0) text_q[p] = byte_t'($urandom_range(0, 255));
      1: text_q.insert(p, byte_t'($urandom_range(0, 255)));
      2: if (text_q.size() > 0) text_q.delete(p);
      default: text_q.insert(p, $urandom_range(0, 1) ? CH_COLON : CH_DOT);
    endcase
  endtask

  initial begin
    string s;
    int r;
    items_sent = 0; strings_sent = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_text();
    send_string("0.0.0.0");
    send_string("255.255.255.255");
    send_string("8.8.8.8");
    send_string("01.2.3.4");
    send_string("1.2.3.256");
    send_string("1.2.3");
    send_string("::");
    send_string("::1");
    send_string("1:2:3:4:5:6:7:8");
    send_string("FFFF:ffff:0:0:0:0:0:1");
    send_string("1::2::3");
    send_string("::ffff:10.0.0.1");
    send_string("::8.8.8.8");
    send_string("64:ff9b::1.1.1.1");
    send_string("fe80::1");
    send_string("fd00::");
    send_string("2001:db8::1.2.3.04");
    send_string("12345::");
    text_q = '{"1", ".", "2", ".", "3", ".", "4", 8'h00};
    send_text();
    noise_text(70);
    send_text();

    while (items_sent < 1950) begin
      r = $urandom_range(0, 99);
      if (r < 35) s = dotted_quad();
      else if (r < 78) s = hex_literal();
      else s = "";
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      if (r >= 78) noise_text($urandom_range(0, 2) == 0 ? $urandom_range(0, 40)
                                                         : $urandom_range(0, 10));
      else if ($urandom_range(0, 5) == 0) damage_text();
      send_text();
    end

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d strings in %0d requests; %0d results checked",
             strings_sent, items_sent, results);
    if (fail_count == 0) begin
      $display("** ip_literal_private_classifier_unit: PASSED **");
    end else begin
      $display("** ip_literal_private_classifier_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ipcls_pkg.sv
rtl/ipcls_if.sv
rtl/ip_literal_private_classifier_unit.sv
rtl/ipcls_checker.sv
tb/ipcls_checker.sv
tb/testbench.sv
